@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SHDEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SHDEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/shdec_pkg.sv @@
package shdec_pkg;

    localparam int CMD_W  = 3;
    localparam int ST_W   = 9;
    localparam int SYM_W  = 8;
    localparam int LANE_W = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEED        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STEP_ACTUAL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP_LANES  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESOLVE     = 3'd4;

    typedef logic [ST_W-1:0]   t_state;
    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [LANE_W-1:0] t_lane;

    typedef enum logic [2:0] {
        K_NONE,
        K_LOAD,
        K_SEED,
        K_STEP_ACTUAL,
        K_STEP_LANES,
        K_RESOLVE
    } t_kind;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_kind  kind;
        t_state index;
        t_state nz;
        t_state no;
        t_sym   sym;
        logic   leaf;
        t_lane  lane;
        t_state seed;
        logic   code_bit;
    } t_req;

    // One result as it leaves the back.
    typedef struct packed {
        t_state actual;
        t_sym   sym;
        logic   at_leaf;
        logic   hit;
        t_lane  hit_lane;
    } t_res;

endpackage

@@ src/shdec_if.sv @@
interface shdec_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                command;
    logic [8:0]                entry_index;
    logic [8:0]                next_if_zero;
    logic [8:0]                next_if_one;
    logic [7:0]                entry_symbol;
    logic                      entry_is_leaf;
    logic [3:0]                lane_number;
    logic [8:0]                seed_state;
    logic                      code_bit;

    modport source (
        output valid, command, entry_index, next_if_zero, next_if_one,
               entry_symbol, entry_is_leaf, lane_number, seed_state, code_bit,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, next_if_zero, next_if_one,
               entry_symbol, entry_is_leaf, lane_number, seed_state, code_bit,
        output ready
    );
endinterface

interface shdec_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] actual_state_out;
    logic [7:0] symbol_out;
    logic       at_leaf;
    logic       spec_hit;
    logic [3:0] hit_lane;

    modport source (
        output valid, actual_state_out, symbol_out, at_leaf, spec_hit, hit_lane,
        input  ready
    );
    modport sink (
        input  valid, actual_state_out, symbol_out, at_leaf, spec_hit, hit_lane,
        output ready
    );
endinterface

@@ src/speculative_huffman_fsm_decoder_core.sv @@
// A request is queued in the front, executed in the back, then passed to the output register.
// Throughput: one request per cycle unless the output stalls; the state update and the registered
// table read of the next state coincide, one table copy per lane and one for the actual state.
// Reset (i_rst_n, synchronous, active low) clears the actual state, all lane start and running
// states, the queue and the output register; table memories are not cleared and must be
// loaded before they are read.
module speculative_huffman_fsm_decoder_core #(
    parameter int MAX_STATES = 512,
    parameter int LANES      = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    shdec_in_if.sink     i_in,
    shdec_out_if.source  o_out
);

    // The front accepts requests and classifies their commands into a short queue.
    // The back owns the decoder state: it executes one queued request per cycle unless its result
    // is held up, and presents the result in the cycle after, once the table read of the new actual
    // state has come back. The output register here parts the back from the consumer.

    logic            w_q_valid;
    shdec_pkg::t_req w_q_req;
    logic            w_q_pop;
    logic            w_res_valid;
    shdec_pkg::t_res w_res;
    logic            w_res_ready;

    logic            r_o_valid;
    shdec_pkg::t_res r_o_res;

    shdec_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_req   (w_q_req),
        .i_q_pop   (w_q_pop)
    );

    shdec_back #(
        .MAX_STATES (MAX_STATES),
        .LANES      (LANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_req     (w_q_req),
        .o_q_pop     (w_q_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign w_res_ready = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_o_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_o_res <= w_res;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.actual_state_out = r_o_res.actual;
    assign o_out.symbol_out       = r_o_res.sym;
    assign o_out.at_leaf          = r_o_res.at_leaf;
    assign o_out.spec_hit         = r_o_res.hit;
    assign o_out.hit_lane         = r_o_res.hit_lane;

endmodule

@@ src/shdec_front.sv @@
module shdec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    shdec_in_if.sink          i_in,
    output logic              o_q_valid,
    output shdec_pkg::t_req   o_q_req,
    input  logic              i_q_pop
);

    localparam int QD = 4;

    shdec_pkg::t_req r_q [QD];
    logic [1:0]      r_wr_ptr, n_wr_ptr;
    logic [1:0]      r_rd_ptr, n_rd_ptr;
    logic [2:0]      r_count, n_count;
    shdec_pkg::t_req w_req;
    logic            w_push;

    // Classify the command into the kind of work the back has to do.
    always_comb begin
        w_req.index    = i_in.entry_index;
        w_req.nz       = i_in.next_if_zero;
        w_req.no       = i_in.next_if_one;
        w_req.sym      = i_in.entry_symbol;
        w_req.leaf     = i_in.entry_is_leaf;
        w_req.lane     = i_in.lane_number;
        w_req.seed     = i_in.seed_state;
        w_req.code_bit = i_in.code_bit;
        case (i_in.command)
            shdec_pkg::CMD_LOAD:        w_req.kind = shdec_pkg::K_LOAD;
            shdec_pkg::CMD_SEED:        w_req.kind = shdec_pkg::K_SEED;
            shdec_pkg::CMD_STEP_ACTUAL: w_req.kind = shdec_pkg::K_STEP_ACTUAL;
            shdec_pkg::CMD_STEP_LANES:  w_req.kind = shdec_pkg::K_STEP_LANES;
            shdec_pkg::CMD_RESOLVE:     w_req.kind = shdec_pkg::K_RESOLVE;
            default:                    w_req.kind = shdec_pkg::K_NONE;
        endcase
    end

    assign i_in.ready = (r_count != 3'(QD));
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != 3'd0);
    assign o_q_req    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push  ? r_wr_ptr + 2'd1 : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + 2'd1 : r_rd_ptr;
        n_count  = r_count + 3'(w_push) - 3'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_req;
        end
    end

endmodule

@@ src/shdec_back.sv @@
`include "assert_macros.svh"

module shdec_back #(
    parameter int MAX_STATES = 512,
    parameter int LANES      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  shdec_pkg::t_req   i_q_req,
    output logic              o_q_pop,
    output logic              o_res_valid,
    output shdec_pkg::t_res   o_res,
    input  logic              i_res_ready
);

    localparam int AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SW = shdec_pkg::ST_W;
    localparam int LW = shdec_pkg::LANE_W;

    typedef struct packed {
        shdec_pkg::t_state nz;
        shdec_pkg::t_state no;
    } t_link;

    typedef struct packed {
        shdec_pkg::t_state nz;
        shdec_pkg::t_state no;
        shdec_pkg::t_sym   sym;
        logic              leaf;
    } t_entry;

    logic              w_exec;
    logic              w_wr;
    logic [AW-1:0]     w_waddr;
    t_entry            w_wentry;
    t_link             w_wlink;

    shdec_pkg::t_state r_act, n_act;
    logic              r_act_inr;
    t_entry            r_act_rd;
    t_entry            r_act_mem [MAX_STATES];
    logic [AW-1:0]     w_act_raddr;

    shdec_pkg::t_state r_start [LANES];
    shdec_pkg::t_state n_start [LANES];
    shdec_pkg::t_state r_cur   [LANES];
    shdec_pkg::t_state n_cur   [LANES];
    logic              w_cur_inr [LANES];
    t_link             w_lane_rd [LANES];

    logic              w_hit;
    shdec_pkg::t_lane  w_hit_lane;
    logic              r_p_valid;
    logic              r_p_hit;
    shdec_pkg::t_lane  r_p_lane;

    assign w_exec  = i_q_valid && (!r_p_valid || i_res_ready);
    assign o_q_pop = w_exec;

    assign w_wr     = w_exec && (i_q_req.kind == shdec_pkg::K_LOAD)
                   && ({{(32-SW){1'b0}}, i_q_req.index} < MAX_STATES);
    assign w_waddr  = AW'(i_q_req.index);
    assign w_wentry = '{nz: i_q_req.nz, no: i_q_req.no, sym: i_q_req.sym,
                        leaf: i_q_req.leaf};
    assign w_wlink  = '{nz: i_q_req.nz, no: i_q_req.no};

    // Next actual state; a resolve takes the lowest lane whose start matches.
    always_comb begin
        logic found;
        found      = 1'b0;
        w_hit_lane = '0;
        n_act      = r_act;
        if (w_exec && (i_q_req.kind == shdec_pkg::K_STEP_ACTUAL)) begin
            n_act = !r_act_inr ? '0 : (i_q_req.code_bit ? r_act_rd.no : r_act_rd.nz);
        end
        for (int k = 0; k < LANES; k++) begin
            if (!found && (r_start[k] == r_act)) begin
                found      = 1'b1;
                w_hit_lane = LW'(k);
                if (w_exec && (i_q_req.kind == shdec_pkg::K_RESOLVE)) begin
                    n_act = r_cur[k];
                end
            end
        end
        w_hit = found && w_exec && (i_q_req.kind == shdec_pkg::K_RESOLVE);
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_start[k] = r_start[k];
            n_cur[k]   = r_cur[k];
            if (w_exec && (i_q_req.kind == shdec_pkg::K_SEED)
                    && ({{(32-LW){1'b0}}, i_q_req.lane} == k)) begin
                n_start[k] = i_q_req.seed;
                n_cur[k]   = i_q_req.seed;
            end else if (w_exec && (i_q_req.kind == shdec_pkg::K_STEP_LANES)) begin
                n_cur[k] = !w_cur_inr[k] ? '0
                         : (i_q_req.code_bit ? w_lane_rd[k].no : w_lane_rd[k].nz);
            end
        end
    end

    // The table copy of the actual state is read at the next state every cycle,
    // so its read register always holds the entry of the current state.
    assign w_act_raddr = AW'(n_act);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_act_mem[w_waddr] <= w_wentry;
        end
        if (w_wr && (w_waddr == w_act_raddr)) begin
            r_act_rd <= w_wentry;
        end else begin
            r_act_rd <= r_act_mem[w_act_raddr];
        end
        r_act_inr <= ({{(32-SW){1'b0}}, n_act} < MAX_STATES);
    end

    // Each lane has its own copy of the link fields to step all lanes at once.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        t_link         r_lmem [MAX_STATES];
        t_link         r_rd;
        logic          r_inr;
        logic [AW-1:0] w_raddr;

        assign w_raddr      = AW'(n_cur[g]);
        assign w_lane_rd[g] = r_rd;
        assign w_cur_inr[g] = r_inr;

        always_ff @(posedge i_clk) begin
            if (w_wr) begin
                r_lmem[w_waddr] <= w_wlink;
            end
            if (w_wr && (w_waddr == w_raddr)) begin
                r_rd <= w_wlink;
            end else begin
                r_rd <= r_lmem[w_raddr];
            end
            r_inr <= ({{(32-SW){1'b0}}, n_cur[g]} < MAX_STATES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= '0;
            r_p_valid <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                r_start[k] <= '0;
                r_cur[k]   <= '0;
            end
        end else begin
            r_act <= n_act;
            for (int k = 0; k < LANES; k++) begin
                r_start[k] <= n_start[k];
                r_cur[k]   <= n_cur[k];
            end
            if (!r_p_valid || i_res_ready) begin
                r_p_valid <= w_exec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_p_hit  <= w_hit;
            r_p_lane <= w_hit ? w_hit_lane : '0;
        end
    end

    always_comb begin
        o_res_valid      = r_p_valid;
        o_res.actual     = r_act;
        o_res.at_leaf    = r_act_inr && r_act_rd.leaf;
        o_res.sym        = o_res.at_leaf ? r_act_rd.sym : '0;
        o_res.hit        = r_p_hit;
        o_res.hit_lane   = r_p_lane;
    end

    `SHDEC_ASSERT_NEXT(a_miss_keeps_actual, w_exec && (i_q_req.kind == shdec_pkg::K_RESOLVE) && !w_hit, $stable(r_act))
    `SHDEC_ASSERT_NEXT(a_stall_holds_result, r_p_valid && !i_res_ready, r_p_valid && $stable(r_act))
    `SHDEC_ASSERT_NOW(a_hit_lane_exists, r_p_valid && r_p_hit, 32'(r_p_lane) < LANES)

endmodule

@@ tb/sv/speculative_huffman_fsm_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module speculative_huffman_fsm_decoder_core_tb;

    localparam int N_STATES    = 512;
    localparam int N_LANES     = 16;
    localparam int STALL_LIMIT = 3000;

    // Command codes the block has no use for; they must only report status.
    localparam logic [shdec_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [shdec_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [shdec_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // One request as the sender offers it.
    typedef struct {
        logic [shdec_pkg::CMD_W-1:0] command;
        shdec_pkg::t_state           index;
        shdec_pkg::t_state           nz;
        shdec_pkg::t_state           no;
        shdec_pkg::t_sym             sym;
        logic                        leaf;
        shdec_pkg::t_lane            lane;
        shdec_pkg::t_state           seed;
        logic                        code_bit;
    } huff_req_t;

    // Keeps its own copy of the decoder tables and lanes, and a queue of the
    // status words that accepted requests are due to produce.
    class huff_scoreboard;
        shdec_pkg::t_state zero_next [N_STATES];
        shdec_pkg::t_state one_next  [N_STATES];
        shdec_pkg::t_sym   sym_tab   [N_STATES];
        logic              leaf_tab  [N_STATES];
        shdec_pkg::t_state start_st  [N_LANES];
        shdec_pkg::t_state run_st    [N_LANES];
        shdec_pkg::t_state actual;
        shdec_pkg::t_res   pending[$];
        int                errors;

        function new();
            for (int i = 0; i < N_STATES; i++) begin
                zero_next[i] = '0;
                one_next[i]  = '0;
                sym_tab[i]   = '0;
                leaf_tab[i]  = 1'b0;
            end
            for (int k = 0; k < N_LANES; k++) begin
                start_st[k] = '0;
                run_st[k]   = '0;
            end
            actual = '0;
            errors = 0;
        endfunction

        function shdec_pkg::t_state walk(shdec_pkg::t_state s, logic b);
            return b ? one_next[s] : zero_next[s];
        endfunction

        function void note_request(huff_req_t r);
            shdec_pkg::t_res e;
            e = '0;
            case (r.command)
                shdec_pkg::CMD_LOAD: begin
                    zero_next[r.index] = r.nz;
                    one_next[r.index]  = r.no;
                    sym_tab[r.index]   = r.sym;
                    leaf_tab[r.index]  = r.leaf;
                end
                shdec_pkg::CMD_SEED: begin
                    start_st[r.lane] = r.seed;
                    run_st[r.lane]   = r.seed;
                end
                shdec_pkg::CMD_STEP_ACTUAL: actual = walk(actual, r.code_bit);
                shdec_pkg::CMD_STEP_LANES: begin
                    for (int k = 0; k < N_LANES; k++)
                        run_st[k] = walk(run_st[k], r.code_bit);
                end
                shdec_pkg::CMD_RESOLVE: begin
                    // The lowest lane whose seed equals the actual state wins.
                    for (int k = 0; k < N_LANES; k++) begin
                        if (!e.hit && start_st[k] == actual) begin
                            e.hit      = 1'b1;
                            e.hit_lane = shdec_pkg::t_lane'(k);
                        end
                    end
                    if (e.hit) actual = run_st[e.hit_lane];
                end
                default: ;
            endcase
            e.actual  = actual;
            e.at_leaf = leaf_tab[actual];
            e.sym     = leaf_tab[actual] ? sym_tab[actual] : '0;
            pending = {pending, e};
        endfunction

        function void check_result(shdec_pkg::t_res got);
            shdec_pkg::t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.actual !== e.actual) begin
                $display("%0t: actual_state_out expected %0d got %0d", $time, e.actual,
                         got.actual);
                errors++;
            end
            if (got.sym !== e.sym) begin
                $display("%0t: symbol_out expected %0d got %0d", $time, e.sym, got.sym);
                errors++;
            end
            if (got.at_leaf !== e.at_leaf) begin
                $display("%0t: at_leaf expected %0b got %0b", $time, e.at_leaf, got.at_leaf);
                errors++;
            end
            if (got.hit !== e.hit) begin
                $display("%0t: spec_hit expected %0b got %0b", $time, e.hit, got.hit);
                errors++;
            end
            if (got.hit_lane !== e.hit_lane) begin
                $display("%0t: hit_lane expected %0d got %0d", $time, e.hit_lane,
                         got.hit_lane);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    shdec_in_if  in_if ();
    shdec_out_if out_if ();

    speculative_huffman_fsm_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    huff_scoreboard sb = new();

    // Table entries the stimulus has loaded. Every state the decoder can
    // reach is kept inside this set, so no unloaded entry is ever read.
    bit  loaded [N_STATES];
    int  loaded_list[$];
    int  idle_count;
    bit  hold_request;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Results are compared at the rising edge where the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result({out_if.actual_state_out, out_if.symbol_out, out_if.at_leaf,
                             out_if.spec_hit, out_if.hit_lane});
        end
    end

    // Watchdog: any cycle without a request or a result moving counts
    // toward the limit, and a handshake on either side starts it over.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Receiver. It stalls at random, with stretches of steady ready.
    // On request it holds off once for a long stretch so that the block
    // backs up and has to stall its own input.
    initial begin : receiver
        int hold_left;
        int cyc;
        bit held;
        hold_left = 0;
        cyc = 0;
        held = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_request && !held) begin
                hold_left = 300;
                held = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if ((cyc / 64) % 3 == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic mark_loaded(int idx);
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list = {loaded_list, idx};
        end
    endtask

    function automatic shdec_pkg::t_state any_loaded();
        return shdec_pkg::t_state'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    // Offers one request and holds it until it is taken. The predictor
    // is updated at the edge where the request is accepted.
    task automatic send(huff_req_t r);
        @(negedge i_clk);
        in_if.valid         <= 1'b1;
        in_if.command       <= r.command;
        in_if.entry_index   <= r.index;
        in_if.next_if_zero  <= r.nz;
        in_if.next_if_one   <= r.no;
        in_if.entry_symbol  <= r.sym;
        in_if.entry_is_leaf <= r.leaf;
        in_if.lane_number   <= r.lane;
        in_if.seed_state    <= r.seed;
        in_if.code_bit      <= r.code_bit;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(r);
        if (r.command == shdec_pkg::CMD_LOAD) mark_loaded(int'(r.index));
    endtask

    task automatic pause(int cycles);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    function automatic huff_req_t blank_req(logic [shdec_pkg::CMD_W-1:0] cmd);
        huff_req_t r;
        r.command  = cmd;
        r.index    = '0;
        r.nz       = '0;
        r.no       = '0;
        r.sym      = '0;
        r.leaf     = 1'b0;
        r.lane     = '0;
        r.seed     = '0;
        r.code_bit = 1'b0;
        return r;
    endfunction

    function automatic huff_req_t load_req(int idx, int nz, int no, int sym, bit leaf);
        huff_req_t r;
        r       = blank_req(shdec_pkg::CMD_LOAD);
        r.index = shdec_pkg::t_state'(idx);
        r.nz    = shdec_pkg::t_state'(nz);
        r.no    = shdec_pkg::t_state'(no);
        r.sym   = shdec_pkg::t_sym'(sym);
        r.leaf  = leaf;
        return r;
    endfunction

    function automatic huff_req_t step_req(logic [shdec_pkg::CMD_W-1:0] cmd, bit b);
        huff_req_t r;
        r = blank_req(cmd);
        r.code_bit = b;
        return r;
    endfunction

    function automatic huff_req_t seed_req(int lane, int st);
        huff_req_t r;
        r = blank_req(shdec_pkg::CMD_SEED);
        r.lane = shdec_pkg::t_lane'(lane);
        r.seed = shdec_pkg::t_state'(st);
        return r;
    endfunction

    // Random request. Loads point only at entries already loaded (or at
    // themselves); seeds often copy the actual state so that resolves hit.
    function automatic huff_req_t random_req();
        huff_req_t r;
        int pick;
        int idx;
        r = blank_req(CMD_SPARE_5);
        // Noise in the fields a command does not use.
        r.index = shdec_pkg::t_state'($urandom);
        r.sym   = shdec_pkg::t_sym'($urandom);
        r.lane  = shdec_pkg::t_lane'($urandom);
        r.code_bit = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            idx     = $urandom_range(0, N_STATES - 1);
            r.command = shdec_pkg::CMD_LOAD;
            r.index = shdec_pkg::t_state'(idx);
            r.nz    = ($urandom_range(0, 4) == 0) ? shdec_pkg::t_state'(idx) : any_loaded();
            r.no    = ($urandom_range(0, 4) == 0) ? shdec_pkg::t_state'(idx) : any_loaded();
            r.leaf  = 1'($urandom_range(0, 1));
        end else if (pick < 45) begin
            r.command = shdec_pkg::CMD_SEED;
            r.seed  = ($urandom_range(0, 1) == 0) ? sb.actual : any_loaded();
        end else if (pick < 65) begin
            r.command = shdec_pkg::CMD_STEP_ACTUAL;
            r.nz = any_loaded();
        end else if (pick < 80) begin
            r.command = shdec_pkg::CMD_STEP_LANES;
            r.seed = any_loaded();
        end else if (pick < 95) begin
            r.command = shdec_pkg::CMD_RESOLVE;
        end else begin
            r.command = shdec_pkg::CMD_W'(CMD_SPARE_5 + $urandom_range(0, 2));
            r.nz = shdec_pkg::t_state'($urandom);
            r.no = shdec_pkg::t_state'($urandom);
            r.seed = shdec_pkg::t_state'($urandom);
            r.leaf = 1'($urandom_range(0, 1));
        end
        return r;
    endfunction

    initial begin : stimulus
        int burst_left;
        int waited;
        huff_req_t r;

        // Known values on every input before the first edge.
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.command         = shdec_pkg::CMD_LOAD;
        in_if.entry_index     = '0;
        in_if.next_if_zero    = '0;
        in_if.next_if_one     = '0;
        in_if.entry_symbol    = '0;
        in_if.entry_is_leaf   = 1'b0;
        in_if.lane_number     = '0;
        in_if.seed_state      = '0;
        in_if.code_bit        = 1'b0;
        hold_request          = 1'b0;
        for (int i = 0; i < N_STATES; i++) loaded[i] = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The root must be loaded first because every status
        // word reads the entry of the actual state.
        send(load_req(0, 0, 0, 0, 1'b0));
        send(load_req(511, 511, 0, 255, 1'b1));
        send(load_req(1, 511, 1, 8'h5A, 1'b1));
        send(load_req(0, 1, 511, 8'hA5, 1'b0));
        send(step_req(shdec_pkg::CMD_STEP_ACTUAL, 1'b1));   // root to the top state
        send(step_req(shdec_pkg::CMD_STEP_ACTUAL, 1'b0));   // top state loops on itself
        send(step_req(shdec_pkg::CMD_STEP_ACTUAL, 1'b1));   // back to the root
        send(seed_req(0, 0));
        send(seed_req(15, 511));
        send(step_req(shdec_pkg::CMD_STEP_LANES, 1'b0));
        send(step_req(shdec_pkg::CMD_STEP_LANES, 1'b1));
        send(blank_req(shdec_pkg::CMD_RESOLVE));            // lane zero hits
        send(blank_req(shdec_pkg::CMD_RESOLVE));            // nothing starts at state 1: a miss
        send(seed_req(0, 511));
        send(step_req(shdec_pkg::CMD_STEP_ACTUAL, 1'b0));
        send(blank_req(shdec_pkg::CMD_RESOLVE));   // lanes zero and fifteen match, lowest wins
        send(load_req(511, 511, 511, 255, 1'b1));
        r = blank_req(CMD_SPARE_5);
        r.index = '1; r.nz = '1; r.no = '1; r.sym = '1; r.leaf = 1'b1;
        r.lane = '1; r.seed = '1; r.code_bit = 1'b1;
        send(r);
        r.command = CMD_SPARE_6;
        send(r);
        r.command = CMD_SPARE_7;
        send(r);
        send(seed_req(15, 0));
        send(blank_req(shdec_pkg::CMD_RESOLVE));

        // Random part, sent in bursts with gaps between them.
        burst_left = 0;
        for (int n = 0; n < 400; n++) begin
            if (n == 150) hold_request = 1'b1;
            if (burst_left == 0) begin
                if (n < 150 || n > 220) pause($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            send(random_req());
        end
        pause(1);

        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d results never arrived", $time, sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
